### design/ptrd_pkg.sv
// ----------------------------------------------------------------------------
// ptrd_pkg : shared types and constants of the piezo touch/release detector
// Filter coefficients, window sizing, register map and the structs that
// pass between the top level and its sensor lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package ptrd_pkg;

  // Sample and filter widths
  localparam int SAMPLE_BITS = 10;
  localparam int FILT_BITS   = 12;
  localparam int Y_W         = 16;
  localparam int SUM_W       = Y_W + 2;
  localparam int TAP_W       = SAMPLE_BITS + 2;
  localparam int FF_W        = TAP_W + 2;
  localparam int FB1_W       = Y_W + 11;
  localparam int FB2_W       = Y_W + 10;
  localparam int FILT_SHIFT  = 10;

  // Filter coefficients (scaled by 1024)
  localparam int FB1_COEF = 1889;
  localparam int FB2_COEF = 875;

  // Detection window
  localparam int WINDOW_LEN      = 10;
  localparam int EVENT_MIN_COUNT = 6;
  localparam int WPOS_W          = $clog2(WINDOW_LEN + 1);
  localparam int CNT_W           = $clog2(WINDOW_LEN + 1);

  // Configuration widths and reset values
  localparam int THR_W  = 12;
  localparam int TIME_W = 10;
  localparam int WAIT_W = TIME_W + 1;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [THR_W-1:0]  TOUCH_THR_RST   = THR_W'(776);
  localparam logic [THR_W-1:0]  RELEASE_THR_RST = THR_W'(62);
  localparam logic [TIME_W-1:0] STIM_TIME_RST   = TIME_W'(50);
  localparam logic [TIME_W-1:0] REFR_BASE_RST   = TIME_W'(140);
  localparam logic [1:0]        ACTIVE_SENS_RST = 2'd2;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_TOUCH_THR_A   = 3'd0,
    REG_TOUCH_THR_B   = 3'd1,
    REG_RELEASE_THR_A = 3'd2,
    REG_RELEASE_THR_B = 3'd3,
    REG_STIM_TIME     = 3'd4,
    REG_REFR_BASE     = 3'd5,
    REG_MOTOR_EN      = 3'd6,
    REG_ACTIVE_SENS   = 3'd7
  } reg_idx_t;

  // Per-tick control from the top level to one lane
  typedef struct packed {
    logic step;
    logic window_end;
    logic active;
  } lane_ctrl_t;

  // Per-tick result of one lane
  typedef struct packed {
    logic [FILT_BITS-1:0] filtered;
    logic                 contact_evt;
    logic                 release_evt;
    logic                 pulse_on;
  } lane_res_t;

endpackage

`default_nettype wire

### design/ptrd_lane.sv
// ----------------------------------------------------------------------------
// ptrd_lane : one sensor lane
// Second-order low-pass filter, window counters, refractory timer and
// stimulation pulse counter. State advances on ctrl.step.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrd_lane (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ptrd_pkg::lane_ctrl_t           ctrl,
  input  wire logic [ptrd_pkg::SAMPLE_BITS-1:0] sample,
  input  wire logic [ptrd_pkg::THR_W-1:0]     touch_thr,
  input  wire logic [ptrd_pkg::THR_W-1:0]     rel_thr,
  input  wire logic [ptrd_pkg::TIME_W-1:0]    stim_time,
  input  wire logic [ptrd_pkg::WAIT_W-1:0]    wait_time,
  output ptrd_pkg::lane_res_t                 res
);

  logic [ptrd_pkg::SAMPLE_BITS-1:0] x1_r, x2_r;
  logic [ptrd_pkg::Y_W-1:0]         y1_r, y2_r, y_nxt;
  logic [ptrd_pkg::CNT_W-1:0]       tcnt_r, rcnt_r, tcnt_nxt, rcnt_nxt;
  logic [ptrd_pkg::CNT_W-1:0]       tcnt_inc, rcnt_inc;
  logic [15:0]                      refr_r, refr_nxt, refr_inc;
  logic [15:0]                      pcnt_r, pcnt_nxt, pcnt_inc;
  logic                             pact_r, pact_nxt;

  logic [ptrd_pkg::TAP_W-1:0] tap_sum;
  logic [ptrd_pkg::FF_W-1:0]  ff_prod;
  logic [ptrd_pkg::FB1_W-1:0] fb1_prod;
  logic [ptrd_pkg::FB2_W-1:0] fb2_prod;
  logic [ptrd_pkg::SUM_W-1:0] pos_sum, fb2_ext, y_full;
  logic                       touch_hit, rel_hit, fire, contact, rel_evt, evt;

  // Feed-forward taps: x + 2*x1 + x2, times three
  assign tap_sum = ptrd_pkg::TAP_W'(sample) + {1'b0, x1_r, 1'b0}
                   + ptrd_pkg::TAP_W'(x2_r);
  assign ff_prod = {1'b0, tap_sum, 1'b0} + ptrd_pkg::FF_W'(tap_sum);

  // Feedback products
  assign fb1_prod = ptrd_pkg::FB1_W'(y1_r) * ptrd_pkg::FB1_W'(ptrd_pkg::FB1_COEF);
  assign fb2_prod = ptrd_pkg::FB2_W'(y2_r) * ptrd_pkg::FB2_W'(ptrd_pkg::FB2_COEF);

  // Sum, clamp at zero and saturate the stored output
  always_comb begin
    pos_sum = ptrd_pkg::SUM_W'(ff_prod >> ptrd_pkg::FILT_SHIFT)
              + ptrd_pkg::SUM_W'(fb1_prod >> ptrd_pkg::FILT_SHIFT);
    fb2_ext = ptrd_pkg::SUM_W'(fb2_prod >> ptrd_pkg::FILT_SHIFT);
    y_full  = (pos_sum > fb2_ext) ? (pos_sum - fb2_ext) : '0;
    y_nxt   = (|y_full[ptrd_pkg::SUM_W-1:ptrd_pkg::Y_W]) ? '1 : y_full[ptrd_pkg::Y_W-1:0];
  end

  // Window counters and event decision
  always_comb begin
    touch_hit = (y_nxt >= ptrd_pkg::Y_W'(touch_thr));
    rel_hit   = !touch_hit && (y_nxt <= ptrd_pkg::Y_W'(rel_thr));
    tcnt_inc  = tcnt_r + ptrd_pkg::CNT_W'(touch_hit);
    rcnt_inc  = rcnt_r + ptrd_pkg::CNT_W'(rel_hit);
    refr_inc  = ctrl.active && (refr_r != 16'hFFFF) ? refr_r + 16'd1 : refr_r;
    pcnt_inc  = (pcnt_r != 16'hFFFF) ? pcnt_r + 16'd1 : pcnt_r;
    fire      = ctrl.window_end && ctrl.active && (refr_inc > 16'(wait_time));
    contact   = fire && (32'(tcnt_inc) >= ptrd_pkg::EVENT_MIN_COUNT);
    rel_evt   = fire && !contact && (32'(rcnt_inc) >= ptrd_pkg::EVENT_MIN_COUNT);
    evt       = contact || rel_evt;
    tcnt_nxt  = ctrl.window_end ? '0 : tcnt_inc;
    rcnt_nxt  = ctrl.window_end ? '0 : rcnt_inc;
    refr_nxt  = evt ? '0 : refr_inc;
    pcnt_nxt  = evt ? '0 : pcnt_inc;
    pact_nxt  = (evt || pact_r) && !(pcnt_nxt > 16'(stim_time));
  end

  // Drive the lane result for this tick
  always_comb begin
    res.filtered    = (|y_nxt[ptrd_pkg::Y_W-1:ptrd_pkg::FILT_BITS]) ? '1
                      : y_nxt[ptrd_pkg::FILT_BITS-1:0];
    res.contact_evt = contact;
    res.release_evt = rel_evt;
    res.pulse_on    = pact_nxt;
  end

  // Advance lane state once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r   <= '0;
      x2_r   <= '0;
      y1_r   <= '0;
      y2_r   <= '0;
      tcnt_r <= '0;
      rcnt_r <= '0;
      refr_r <= '0;
      pcnt_r <= '0;
      pact_r <= 1'b0;
    end else if (ctrl.step) begin
      x1_r   <= sample;
      x2_r   <= x1_r;
      y1_r   <= y_nxt;
      y2_r   <= y1_r;
      tcnt_r <= tcnt_nxt;
      rcnt_r <= rcnt_nxt;
      refr_r <= refr_nxt;
      pcnt_r <= pcnt_nxt;
      pact_r <= pact_nxt;
    end
  end

endmodule

`default_nettype wire

### design/piezo_touch_release_detector_top.sv
// ----------------------------------------------------------------------------
// piezo_touch_release_detector_top : two-lane piezo touch/release detector
//
//  channel | direction | handshake         | payload
//  in_     | slave     | tvalid/tready     | tdata: sample_a, sample_b
//  out_    | master    | tvalid/tready     | tdata: filtered, events, pulse, motor
//  cfg_    | APB slave | psel/penable      | 8 registers at 4*index
//
// One tick per clock unless stalled: a sample pair is registered on entry,
// filtered and judged in a single pass from that register into the result register.
// The filter feedback (y1/y2 products, add, clamp) is the critical path.
// While a result waits the input register holds one more transaction, then
// in_tready drops until the result is taken.
// Synchronous active-low reset clears all filter, counter and timer state.
// ----------------------------------------------------------------------------
`default_nettype none

module piezo_touch_release_detector_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input stream
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [23:0]                   in_tdata,   // [9:0] sample_a, [19:10] sample_b
  // result stream
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [31:0]                        out_tdata,  // [11:0] filtered_a,
                                                         // [23:12] filtered_b,
                                                         // [24] contact_a, [25] release_a,
                                                         // [26] contact_b, [27] release_b,
                                                         // [28] active_a, [29] active_b,
                                                         // [30] motor_a, [31] motor_b
  // configuration
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [ptrd_pkg::ADDR_W-1:0]   cfg_paddr,
  input  wire logic [ptrd_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [ptrd_pkg::DATA_W-1:0]        cfg_prdata,
  output logic                               cfg_pready
);

  // Configuration registers
  logic [ptrd_pkg::THR_W-1:0]  touch_thr_a_r, touch_thr_b_r;
  logic [ptrd_pkg::THR_W-1:0]  rel_thr_a_r, rel_thr_b_r;
  logic [ptrd_pkg::TIME_W-1:0] stim_time_r, refr_base_r;
  logic                        motor_en_r;
  logic [1:0]                  active_sens_r;
  ptrd_pkg::reg_idx_t          reg_idx;
  logic                        cfg_wr;

  // Pipeline
  logic                              s0_vld_r, out_vld_r, advance;
  logic [ptrd_pkg::SAMPLE_BITS-1:0]  smp_a_r, smp_b_r;
  logic [31:0]                       out_data_r, out_data_nxt;
  logic [ptrd_pkg::WPOS_W-1:0]       wpos_r, wpos_inc;
  logic                              window_end;
  logic [ptrd_pkg::WAIT_W-1:0]       wait_time;
  ptrd_pkg::lane_ctrl_t              ctrl_a, ctrl_b;
  ptrd_pkg::lane_res_t               res_a, res_b;

  // Register access decode
  assign cfg_pready = 1'b1;
  assign reg_idx    = ptrd_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touch_thr_a_r <= ptrd_pkg::TOUCH_THR_RST;
      touch_thr_b_r <= ptrd_pkg::TOUCH_THR_RST;
      rel_thr_a_r   <= ptrd_pkg::RELEASE_THR_RST;
      rel_thr_b_r   <= ptrd_pkg::RELEASE_THR_RST;
      stim_time_r   <= ptrd_pkg::STIM_TIME_RST;
      refr_base_r   <= ptrd_pkg::REFR_BASE_RST;
      motor_en_r    <= 1'b1;
      active_sens_r <= ptrd_pkg::ACTIVE_SENS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        ptrd_pkg::REG_TOUCH_THR_A:   touch_thr_a_r <= cfg_pwdata[ptrd_pkg::THR_W-1:0];
        ptrd_pkg::REG_TOUCH_THR_B:   touch_thr_b_r <= cfg_pwdata[ptrd_pkg::THR_W-1:0];
        ptrd_pkg::REG_RELEASE_THR_A: rel_thr_a_r   <= cfg_pwdata[ptrd_pkg::THR_W-1:0];
        ptrd_pkg::REG_RELEASE_THR_B: rel_thr_b_r   <= cfg_pwdata[ptrd_pkg::THR_W-1:0];
        ptrd_pkg::REG_STIM_TIME:     stim_time_r   <= cfg_pwdata[ptrd_pkg::TIME_W-1:0];
        ptrd_pkg::REG_REFR_BASE:     refr_base_r   <= cfg_pwdata[ptrd_pkg::TIME_W-1:0];
        ptrd_pkg::REG_MOTOR_EN:      motor_en_r    <= cfg_pwdata[0];
        ptrd_pkg::REG_ACTIVE_SENS:   active_sens_r <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (reg_idx)
      ptrd_pkg::REG_TOUCH_THR_A:   cfg_prdata = 32'(touch_thr_a_r);
      ptrd_pkg::REG_TOUCH_THR_B:   cfg_prdata = 32'(touch_thr_b_r);
      ptrd_pkg::REG_RELEASE_THR_A: cfg_prdata = 32'(rel_thr_a_r);
      ptrd_pkg::REG_RELEASE_THR_B: cfg_prdata = 32'(rel_thr_b_r);
      ptrd_pkg::REG_STIM_TIME:     cfg_prdata = 32'(stim_time_r);
      ptrd_pkg::REG_REFR_BASE:     cfg_prdata = 32'(refr_base_r);
      ptrd_pkg::REG_MOTOR_EN:      cfg_prdata = 32'(motor_en_r);
      ptrd_pkg::REG_ACTIVE_SENS:   cfg_prdata = 32'(active_sens_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  // Flow control: advance the input register whenever the result slot frees
  assign advance   = s0_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s0_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s0_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Hold the accepted samples
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      smp_a_r <= in_tdata[ptrd_pkg::SAMPLE_BITS-1:0];
      smp_b_r <= in_tdata[2*ptrd_pkg::SAMPLE_BITS-1:ptrd_pkg::SAMPLE_BITS];
    end
  end

  // Shared window position
  assign wpos_inc   = wpos_r + ptrd_pkg::WPOS_W'(1);
  assign window_end = (32'(wpos_inc) >= ptrd_pkg::WINDOW_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r <= '0;
    end else if (advance) begin
      wpos_r <= window_end ? '0 : wpos_inc;
    end
  end

  // Lane controls
  assign wait_time = ptrd_pkg::WAIT_W'(refr_base_r) + ptrd_pkg::WAIT_W'(stim_time_r);

  always_comb begin
    ctrl_a.step       = advance;
    ctrl_a.window_end = window_end;
    ctrl_a.active     = (active_sens_r > 2'd0);
    ctrl_b.step       = advance;
    ctrl_b.window_end = window_end;
    ctrl_b.active     = (active_sens_r > 2'd1);
  end

  ptrd_lane u_lane_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl_a),
    .sample    (smp_a_r),
    .touch_thr (touch_thr_a_r),
    .rel_thr   (rel_thr_a_r),
    .stim_time (stim_time_r),
    .wait_time (wait_time),
    .res       (res_a)
  );

  ptrd_lane u_lane_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl_b),
    .sample    (smp_b_r),
    .touch_thr (touch_thr_b_r),
    .rel_thr   (rel_thr_b_r),
    .stim_time (stim_time_r),
    .wait_time (wait_time),
    .res       (res_b)
  );

  // Pack and register the result
  assign out_data_nxt = {res_b.pulse_on && motor_en_r, res_a.pulse_on && motor_en_r,
                         res_b.pulse_on, res_a.pulse_on,
                         res_b.release_evt, res_b.contact_evt,
                         res_a.release_evt, res_a.contact_evt,
                         res_b.filtered, res_a.filtered};

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // Checks
  a_evt_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> !(res_a.contact_evt && res_a.release_evt)
                && !(res_b.contact_evt && res_b.release_evt))
    else $error("contact and release raised together on one lane");

  a_evt_window_end: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !window_end) |-> !(res_a.contact_evt || res_a.release_evt
                                   || res_b.contact_evt || res_b.release_evt))
    else $error("event raised away from a window end");

  a_evt_starts_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (res_a.contact_evt || res_a.release_evt)) |-> res_a.pulse_on)
    else $error("event on lane A did not start a pulse");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready && s0_vld_r) |-> !in_tready)
    else $error("input register would be overwritten while the result stalls");

  a_wpos_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wpos_r) < ptrd_pkg::WINDOW_LEN)
    else $error("window position out of range");

endmodule

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the piezo touch/release detector
// A model of the filter, the window counters, the refractory timers and
// the stimulation pulses predicts every result beat. Streams carry bursty
// samples and a stalling sink. Settings change only while the block is
// idle, with both the extreme and the reset register values among them.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_TAIL  = 8;
  localparam int PHASE_ITEMS = 160;
  localparam int NUM_PHASES  = 8;
  localparam int LANES       = 2;

  // Result beat, laid out as out_tdata from the top bit down
  typedef struct packed {
    logic                           motor_b;
    logic                           motor_a;
    logic                           active_b;
    logic                           active_a;
    logic                           release_b;
    logic                           contact_b;
    logic                           release_a;
    logic                           contact_a;
    logic [ptrd_pkg::FILT_BITS-1:0] filtered_b;
    logic [ptrd_pkg::FILT_BITS-1:0] filtered_a;
  } tick_result_t;

  logic                          clk;
  logic                          rst_n       = 1'b0;
  logic                          in_tvalid   = 1'b0;
  logic                          in_tready;
  logic [23:0]                   in_tdata    = '0;   // [9:0] sample_a, [19:10] sample_b
  logic                          out_tvalid;
  logic                          out_tready  = 1'b0;
  logic [31:0]                   out_tdata;          // [11:0] filtered_a, [23:12] filtered_b,
                                                     // [24] contact_a, [25] release_a,
                                                     // [26] contact_b, [27] release_b,
                                                     // [28] active_a, [29] active_b,
                                                     // [30] motor_a, [31] motor_b
  logic                          cfg_psel    = 1'b0;
  logic                          cfg_penable = 1'b0;
  logic                          cfg_pwrite  = 1'b0;
  logic [ptrd_pkg::ADDR_W-1:0]   cfg_paddr   = '0;
  logic [ptrd_pkg::DATA_W-1:0]   cfg_pwdata  = '0;
  logic [ptrd_pkg::DATA_W-1:0]   cfg_prdata;
  logic                          cfg_pready;

  // Predicted register contents
  logic [ptrd_pkg::THR_W-1:0]  touch_thr [LANES] = '{ptrd_pkg::TOUCH_THR_RST,
                                                     ptrd_pkg::TOUCH_THR_RST};
  logic [ptrd_pkg::THR_W-1:0]  rel_thr   [LANES] = '{ptrd_pkg::RELEASE_THR_RST,
                                                     ptrd_pkg::RELEASE_THR_RST};
  logic [ptrd_pkg::TIME_W-1:0] stim_len          = ptrd_pkg::STIM_TIME_RST;
  logic [ptrd_pkg::TIME_W-1:0] refr_base         = ptrd_pkg::REFR_BASE_RST;
  logic                        motor_on          = 1'b1;
  logic [1:0]                  lanes_active      = ptrd_pkg::ACTIVE_SENS_RST;

  // Predicted lane state
  logic [ptrd_pkg::SAMPLE_BITS-1:0] x_d1 [LANES] = '{default: '0};
  logic [ptrd_pkg::SAMPLE_BITS-1:0] x_d2 [LANES] = '{default: '0};
  logic [ptrd_pkg::Y_W-1:0] y_d1       [LANES] = '{default: '0};
  logic [ptrd_pkg::Y_W-1:0] y_d2       [LANES] = '{default: '0};
  logic [7:0]          touch_cnt  [LANES] = '{default: '0};
  logic [7:0]          rel_cnt    [LANES] = '{default: '0};
  logic [15:0]         refr_timer [LANES] = '{default: '0};
  logic [15:0]         pulse_cnt  [LANES] = '{default: '0};
  logic                pulse_on   [LANES] = '{default: 1'b0};
  int unsigned         win_pos = 0;

  tick_result_t        due_ticks[$];
  tick_result_t        want_beat;
  tick_result_t        got_beat;
  int                  mismatch_count = 0;
  int                  quiet_cycles   = 0;
  int                  burst_left     = 0;
  int                  stall_mode     = 0;
  int                  mode_left      = 0;
  int                  stall_left     = 0;
  int                  beat           = 0;

  piezo_touch_release_detector_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Free-running clock, 2 ns period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Advance the lane model by one tick and queue the beat it produces
  task automatic advance_detector_tick(input logic [ptrd_pkg::SAMPLE_BITS-1:0] samp_a,
                                       input logic [ptrd_pkg::SAMPLE_BITS-1:0] samp_b);
    logic [ptrd_pkg::SAMPLE_BITS-1:0] x;
    int unsigned                      ff, fb1, fb2, acc, y, hold;
    logic [ptrd_pkg::FILT_BITS-1:0]   shown [LANES];
    logic                             fired_c [LANES];
    logic                             fired_r [LANES];
    logic                             lane_on, window_done;
    tick_result_t                     beat_out;
    hold        = refr_base + stim_len;
    win_pos     = win_pos + 1;
    window_done = (win_pos >= ptrd_pkg::WINDOW_LEN);
    for (int l = 0; l < LANES; l++) begin
      x       = (l == 0) ? samp_a : samp_b;
      lane_on = (l < lanes_active);
      if (lane_on) refr_timer[l] = sat16(refr_timer[l]);
      pulse_cnt[l] = sat16(pulse_cnt[l]);

      // Second-order low-pass, clamped at zero and at the state width
      ff  = (3 * (x + 2 * x_d1[l] + x_d2[l])) >> ptrd_pkg::FILT_SHIFT;
      fb1 = (ptrd_pkg::FB1_COEF * y_d1[l]) >> ptrd_pkg::FILT_SHIFT;
      fb2 = (ptrd_pkg::FB2_COEF * y_d2[l]) >> ptrd_pkg::FILT_SHIFT;
      acc = ff + fb1;
      y   = (acc > fb2) ? acc - fb2 : 0;
      if (y > 65535) y = 65535;
      x_d2[l] = x_d1[l];
      x_d1[l] = x;
      y_d2[l] = y_d1[l];
      y_d1[l] = y[ptrd_pkg::Y_W-1:0];

      // Count touch samples first, release samples otherwise
      if (y >= touch_thr[l]) begin
        if (touch_cnt[l] < 8'd255) touch_cnt[l]++;
      end else if (y <= rel_thr[l]) begin
        if (rel_cnt[l] < 8'd255) rel_cnt[l]++;
      end

      // Judge the window once the refractory wait has passed
      fired_c[l] = 1'b0;
      fired_r[l] = 1'b0;
      if (window_done) begin
        if (lane_on && refr_timer[l] > hold) begin
          if (touch_cnt[l] >= ptrd_pkg::EVENT_MIN_COUNT) fired_c[l] = 1'b1;
          else if (rel_cnt[l] >= ptrd_pkg::EVENT_MIN_COUNT) fired_r[l] = 1'b1;
        end
        if (fired_c[l] || fired_r[l]) begin
          refr_timer[l] = '0;
          pulse_cnt[l]  = '0;
          pulse_on[l]   = 1'b1;
        end
        touch_cnt[l] = '0;
        rel_cnt[l]   = '0;
      end

      if (pulse_cnt[l] > stim_len) pulse_on[l] = 1'b0;
      shown[l] = (y > 4095) ? {ptrd_pkg::FILT_BITS{1'b1}} : y[ptrd_pkg::FILT_BITS-1:0];
    end
    if (window_done) win_pos = 0;

    beat_out.filtered_a = shown[0];
    beat_out.filtered_b = shown[1];
    beat_out.contact_a  = fired_c[0];
    beat_out.release_a  = fired_r[0];
    beat_out.contact_b  = fired_c[1];
    beat_out.release_b  = fired_r[1];
    beat_out.active_a   = pulse_on[0];
    beat_out.active_b   = pulse_on[1];
    beat_out.motor_a    = pulse_on[0] && motor_on;
    beat_out.motor_b    = pulse_on[1] && motor_on;
    due_ticks.push_back(beat_out);
  endtask

  // Send one sample pair, opening a new burst after a random gap
  task automatic send_samples(input logic [ptrd_pkg::SAMPLE_BITS-1:0] samp_a,
                              input logic [ptrd_pkg::SAMPLE_BITS-1:0] samp_b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, samp_b, samp_a};
    do @(posedge clk); while (!in_tready);
    advance_detector_tick(samp_a, samp_b);
  endtask

  // One register write: setup cycle, then access cycle
  task automatic write_reg(input ptrd_pkg::reg_idx_t idx,
                           input logic [ptrd_pkg::DATA_W-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      ptrd_pkg::REG_TOUCH_THR_A:   touch_thr[0] = value[ptrd_pkg::THR_W-1:0];
      ptrd_pkg::REG_TOUCH_THR_B:   touch_thr[1] = value[ptrd_pkg::THR_W-1:0];
      ptrd_pkg::REG_RELEASE_THR_A: rel_thr[0]   = value[ptrd_pkg::THR_W-1:0];
      ptrd_pkg::REG_RELEASE_THR_B: rel_thr[1]   = value[ptrd_pkg::THR_W-1:0];
      ptrd_pkg::REG_STIM_TIME:     stim_len     = value[ptrd_pkg::TIME_W-1:0];
      ptrd_pkg::REG_REFR_BASE:     refr_base    = value[ptrd_pkg::TIME_W-1:0];
      ptrd_pkg::REG_MOTOR_EN:      motor_on     = value[0];
      ptrd_pkg::REG_ACTIVE_SENS:   lanes_active = value[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic apply_settings(input logic [ptrd_pkg::THR_W-1:0] ta,
                                input logic [ptrd_pkg::THR_W-1:0] tb,
                                input logic [ptrd_pkg::THR_W-1:0] ra,
                                input logic [ptrd_pkg::THR_W-1:0] rb,
                                input logic [ptrd_pkg::TIME_W-1:0] st,
                                input logic [ptrd_pkg::TIME_W-1:0] bs,
                                input logic me, input logic [1:0] lanes);
    write_reg(ptrd_pkg::REG_TOUCH_THR_A,   ptrd_pkg::DATA_W'(ta));
    write_reg(ptrd_pkg::REG_TOUCH_THR_B,   ptrd_pkg::DATA_W'(tb));
    write_reg(ptrd_pkg::REG_RELEASE_THR_A, ptrd_pkg::DATA_W'(ra));
    write_reg(ptrd_pkg::REG_RELEASE_THR_B, ptrd_pkg::DATA_W'(rb));
    write_reg(ptrd_pkg::REG_STIM_TIME,     ptrd_pkg::DATA_W'(st));
    write_reg(ptrd_pkg::REG_REFR_BASE,     ptrd_pkg::DATA_W'(bs));
    write_reg(ptrd_pkg::REG_MOTOR_EN,      ptrd_pkg::DATA_W'(me));
    write_reg(ptrd_pkg::REG_ACTIVE_SENS,   ptrd_pkg::DATA_W'(lanes));
  endtask

  // Drop the input and hold until every predicted beat has come back
  task automatic wait_for_quiet();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_ticks.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Sample level: 0 touching, 1 resting, 2 near threshold, 3 noise
  function automatic logic [ptrd_pkg::SAMPLE_BITS-1:0] draw_level(input int kind);
    case (kind)
      0:       return ptrd_pkg::SAMPLE_BITS'($urandom_range(700, 1023));
      1:       return ptrd_pkg::SAMPLE_BITS'($urandom_range(0, 40));
      2:       return ptrd_pkg::SAMPLE_BITS'($urandom_range(300, 800));
      default: return ptrd_pkg::SAMPLE_BITS'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic int pick_kind();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return 0;
    if (roll < 7) return 1;
    if (roll < 8) return 2;
    return 3;
  endfunction

  // Held segments of touch or rest, with short broken ones and noise
  task automatic run_random_items(input int count);
    int sent, seg_len, kind_a, kind_b;
    sent = 0;
    while (sent < count) begin
      seg_len = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 9) : $urandom_range(10, 45);
      kind_a  = pick_kind();
      kind_b  = ($urandom_range(0, 2) == 0) ? kind_a : pick_kind();
      repeat (seg_len) begin
        send_samples(draw_level(kind_a), draw_level(kind_b));
        sent++;
      end
    end
  endtask

  task automatic test_sample_extremes();
    send_samples('0, '0);
    send_samples('1, '1);
    send_samples(10'h2AA, 10'h155);
    send_samples(10'h155, 10'h2AA);
    wait_for_quiet();
  endtask

  // Lane A always touches, lane B always rests; no refractory wait
  task automatic test_forced_events();
    apply_settings('0, '1, '0, '1, '0, '0, 1'b1, 2'd3);
    repeat (6) send_samples(ptrd_pkg::SAMPLE_BITS'($urandom),
                            ptrd_pkg::SAMPLE_BITS'($urandom));
    wait_for_quiet();
  endtask

  // No lane detects when none is enabled
  task automatic test_lanes_disabled();
    apply_settings('0, '1, '0, '1, '0, '0, 1'b0, 2'd0);
    repeat (10) send_samples(ptrd_pkg::SAMPLE_BITS'($urandom),
                             ptrd_pkg::SAMPLE_BITS'($urandom));
    wait_for_quiet();
  endtask

  task automatic test_random_phases();
    logic [ptrd_pkg::THR_W-1:0]  ta, tb, ra, rb;
    logic [ptrd_pkg::TIME_W-1:0] st, bs;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: apply_settings(ptrd_pkg::TOUCH_THR_RST, ptrd_pkg::TOUCH_THR_RST,
                          ptrd_pkg::RELEASE_THR_RST, ptrd_pkg::RELEASE_THR_RST,
                          ptrd_pkg::STIM_TIME_RST, ptrd_pkg::REFR_BASE_RST, 1'b1,
                          ptrd_pkg::ACTIVE_SENS_RST);
        1: apply_settings('1, '1, '1, '1, '1, '1, 1'b1, 2'd2);
        2: apply_settings('0, '0, '0, '0, '0, '0, 1'b0, 2'd1);
        default: begin
          ta = ($urandom_range(0, 3) == 0) ? ptrd_pkg::THR_W'($urandom)
                                           : ptrd_pkg::THR_W'($urandom_range(300, 1200));
          tb = ($urandom_range(0, 3) == 0) ? ptrd_pkg::THR_W'($urandom)
                                           : ptrd_pkg::THR_W'($urandom_range(300, 1200));
          ra = ($urandom_range(0, 3) == 0) ? ptrd_pkg::THR_W'($urandom)
                                           : ptrd_pkg::THR_W'($urandom_range(0, 300));
          rb = ($urandom_range(0, 3) == 0) ? ptrd_pkg::THR_W'($urandom)
                                           : ptrd_pkg::THR_W'($urandom_range(0, 300));
          st = ($urandom_range(0, 4) == 0) ? ptrd_pkg::TIME_W'($urandom)
                                           : ptrd_pkg::TIME_W'($urandom_range(0, 30));
          bs = ($urandom_range(0, 4) == 0) ? ptrd_pkg::TIME_W'($urandom)
                                           : ptrd_pkg::TIME_W'($urandom_range(0, 60));
          apply_settings(ta, tb, ra, rb, st, bs, 1'($urandom_range(0, 1)),
                         2'($urandom_range(0, 3)));
        end
      endcase
      run_random_items(PHASE_ITEMS);
      wait_for_quiet();
    end
  endtask

  // Sink stalls: open, coin toss, fixed pattern, or long holds
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    beat++;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (beat % 4 != 3);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(3, 20);
        end
      end
    endcase
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (due_ticks.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none pending, expected nothing, actual %h",
                 $time, out_tdata);
      end else begin
        want_beat = due_ticks.pop_front();
        got_beat  = tick_result_t'(out_tdata);
        check_field("filtered_a", want_beat.filtered_a, got_beat.filtered_a);
        check_field("filtered_b", want_beat.filtered_b, got_beat.filtered_b);
        check_field("contact_a",  want_beat.contact_a,  got_beat.contact_a);
        check_field("release_a",  want_beat.release_a,  got_beat.release_a);
        check_field("contact_b",  want_beat.contact_b,  got_beat.contact_b);
        check_field("release_b",  want_beat.release_b,  got_beat.release_b);
        check_field("active_a",   want_beat.active_a,   got_beat.active_a);
        check_field("active_b",   want_beat.active_b,   got_beat.active_b);
        check_field("motor_a",    want_beat.motor_a,    got_beat.motor_a);
        check_field("motor_b",    want_beat.motor_b,    got_beat.motor_b);
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_sample_extremes();
    test_forced_events();
    test_lanes_disabled();
    test_random_phases();

    wait_for_quiet();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
